### design/pagerank_push_engine_core_macros.svh
// Assertion macros used by the checker module prpe_chk.
`ifndef PAGERANK_PUSH_ENGINE_CORE_MACROS_SVH
`define PAGERANK_PUSH_ENGINE_CORE_MACROS_SVH

// Checked at every rising edge outside reset.
`define PRPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PRPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/prpe_pkg.sv
`timescale 1ns / 1ps

package prpe_pkg;

  localparam int RANK_FRAC_BITS = 31;
  localparam int RANK_W = RANK_FRAC_BITS + 1;
  localparam int OFF_W = 17;
  localparam int DAMP_W = 16;
  localparam int CMD_W = 2;
  localparam int IDX_W = 16;
  localparam int OUT_VERT_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_OFFSET = 2'd0,
    CMD_LOAD_EDGE   = 2'd1,
    CMD_RUN         = 2'd2,
    CMD_READ        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 3'd0,
    CFG_DAMPING      = 3'd1,
    CFG_TELEPORT     = 3'd2,
    CFG_INIT_RANK    = 3'd3,
    CFG_ROUND_COUNT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_SH_RD,
    ST_SH_GO,
    ST_SH_DIV,
    ST_PU_RD,
    ST_PU_OFF,
    ST_PU_EDGE,
    ST_PU_SUM,
    ST_PU_ADD,
    ST_UP_RD,
    ST_UP_MUL,
    ST_UP_WR,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

### design/prpe_if.sv
`timescale 1ns / 1ps

interface prpe_req_if;
  logic                            valid;
  logic                            ready;
  logic [prpe_pkg::CMD_W-1:0]      command;
  logic [prpe_pkg::IDX_W-1:0]      index;
  logic [prpe_pkg::OFF_W-1:0]      value;

  modport source (output valid, command, index, value, input ready);
  modport sink (input valid, command, index, value, output ready);
endinterface

interface prpe_res_if;
  logic                            valid;
  logic                            ready;
  logic [prpe_pkg::OUT_VERT_W-1:0] vertex;
  logic [prpe_pkg::RANK_W-1:0]     rank;
  logic                            done_res;

  modport source (output valid, vertex, rank, done_res, input ready);
  modport sink (input valid, vertex, rank, done_res, output ready);
endinterface

### design/prpe_div.sv
`timescale 1ns / 1ps

module prpe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [prpe_pkg::RANK_W-1:0]   dividend,
  input  logic [prpe_pkg::OFF_W-1:0]    divisor,
  output logic                          done,
  output logic [prpe_pkg::RANK_W-1:0]   quotient
);

  localparam int CW = $clog2(prpe_pkg::RANK_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [prpe_pkg::RANK_W-1:0]   q_r, q_nxt;
  logic [prpe_pkg::OFF_W-1:0]    rem_r, rem_nxt;
  logic [prpe_pkg::OFF_W-1:0]    dvs_r, dvs_nxt;
  logic [prpe_pkg::OFF_W:0]      rem_sh;
  logic                          ge;

  assign rem_sh = {rem_r, q_r[prpe_pkg::RANK_W-1]};
  assign ge = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (busy_r) begin
      q_nxt = {q_r[prpe_pkg::RANK_W-2:0], ge};
      rem_nxt = ge ? prpe_pkg::OFF_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[prpe_pkg::OFF_W-1:0];
      cnt_nxt = CW'(cnt_r + 1'b1);
      if (cnt_r == CW'(prpe_pkg::RANK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule

### design/pagerank_push_engine_core.sv
`timescale 1ns / 1ps

// PageRank push engine. Load requests are taken one per cycle while it is idle; a
// read request moves it to a read state, from which the rank goes into the result
// register once the result port is free. A run request walks the graph in three
// passes per round over rank, sum and share memories with a read and a write port
// each: the share pass divides each rank by the vertex's degree in the bit-serial
// divider (zero share without outgoing edges), the push pass reads each vertex's
// offsets and share, then per edge an edge read plus, for an in-range destination,
// a sum read and sum write, and the update pass a sum read, multiply and write. After
// reset the rank and sum memories are cleared, during which no request is taken.
module pagerank_push_engine_core #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  prpe_req_if.sink                          in_ch,
  prpe_res_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [prpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int RW = prpe_pkg::RANK_W;
  localparam int OW = prpe_pkg::OFF_W;
  localparam int DW = prpe_pkg::DAMP_W;
  localparam int PW = RW + DW;

  logic [OW-1:0] off_mem [MAX_VERTICES+1];
  logic [OW-1:0] edge_mem [MAX_EDGES];
  logic [RW-1:0] cur_mem [MAX_VERTICES];
  logic [RW-1:0] sum_mem [MAX_VERTICES];
  logic [RW-1:0] shr_mem [MAX_VERTICES];

  prpe_pkg::state_t state_r, state_nxt;

  logic [10:0]    vc_r;
  logic [DW-1:0]  damp_r;
  logic [RW-1:0]  tele_r;
  logic [RW-1:0]  init_r;
  logic [7:0]     rcnt_r;

  logic [VCW-1:0] vcnt_r, vcnt_nxt;
  logic [VCW-1:0] nv_r, nv_nxt;
  logic [7:0]     rc_r, rc_nxt;
  logic [OW-1:0]  k_r, k_nxt;
  logic [OW-1:0]  hi_r, hi_nxt;
  logic [RW-1:0]  sh_r, sh_nxt;
  logic [VAW-1:0] d_r, d_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic           oor_r, oor_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [prpe_pkg::OUT_VERT_W-1:0] out_vert_r, out_vert_nxt, vert_r, vert_nxt;
  logic [RW-1:0]  out_rank_r, out_rank_nxt;
  logic           out_done_r, out_done_nxt;

  logic [OW-1:0]  lo_q, hi_q, edge_q;
  logic [RW-1:0]  cur_q, sum_q, shr_q;

  logic           off_we, off_re, edge_we, edge_re;
  logic           cur_we, cur_re, sum_we, sum_re, shr_we, shr_re;
  logic [VCW-1:0] off_waddr;
  logic [OW-1:0]  off_wdata, edge_wdata;
  logic [EAW-1:0] edge_waddr;
  logic [VAW-1:0] cur_waddr, cur_raddr, sum_waddr, sum_raddr;
  logic [RW-1:0]  cur_wdata, sum_wdata, shr_wdata;

  logic           div_start, div_done;
  logic [RW-1:0]  div_quot;

  logic           v_more, rc_more, k_more, dst_ok, deg_zero, slot_free, clr_last;
  logic [OW-1:0]  deg;
  logic [VAW-1:0] v_addr;
  logic [RW:0]    push_sum, upd_sum;
  logic [31:0]    in_idx32;

  assign v_addr = vcnt_r[VAW-1:0];
  assign v_more = vcnt_r < nv_r;
  assign rc_more = rc_r < rcnt_r;
  assign k_more = (k_r < hi_r) && (32'(k_r) < 32'(MAX_EDGES));
  assign dst_ok = 32'(edge_q) < 32'(nv_r);
  assign deg = (hi_q > lo_q) ? OW'(hi_q - lo_q) : '0;
  assign deg_zero = deg == '0;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign clr_last = vcnt_r == VCW'(MAX_VERTICES - 1);
  assign push_sum = {1'b0, sum_q} + {1'b0, sh_r};
  assign upd_sum = {1'b0, tele_r} + {1'b0, prod_r[PW-1:DW]};
  assign in_idx32 = 32'(in_ch.index);

  prpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_q),
    .divisor  (deg),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 11'd1;
      damp_r <= 16'd55706;
      tele_r <= '0;
      init_r <= '0;
      rcnt_r <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        prpe_pkg::CFG_VERTEX_COUNT: vc_r <= cfg_wdata[10:0];
        prpe_pkg::CFG_DAMPING:      damp_r <= cfg_wdata[DW-1:0];
        prpe_pkg::CFG_TELEPORT:     tele_r <= cfg_wdata[RW-1:0];
        prpe_pkg::CFG_INIT_RANK:    init_r <= cfg_wdata[RW-1:0];
        prpe_pkg::CFG_ROUND_COUNT:  rcnt_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prpe_pkg::ST_CLEAR: if (clr_last) state_nxt = prpe_pkg::ST_IDLE;
      prpe_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.command == prpe_pkg::CMD_RUN) state_nxt = prpe_pkg::ST_INIT;
        if (in_ch.valid && in_ch.command == prpe_pkg::CMD_READ) state_nxt = prpe_pkg::ST_READ;
      end
      prpe_pkg::ST_INIT: if (!v_more) state_nxt = prpe_pkg::ST_ROUND;
      prpe_pkg::ST_ROUND: state_nxt = rc_more ? prpe_pkg::ST_SH_RD : prpe_pkg::ST_DONE;
      prpe_pkg::ST_SH_RD: state_nxt = v_more ? prpe_pkg::ST_SH_GO : prpe_pkg::ST_PU_RD;
      prpe_pkg::ST_SH_GO: state_nxt = deg_zero ? prpe_pkg::ST_SH_RD : prpe_pkg::ST_SH_DIV;
      prpe_pkg::ST_SH_DIV: if (div_done) state_nxt = prpe_pkg::ST_SH_RD;
      prpe_pkg::ST_PU_RD: state_nxt = v_more ? prpe_pkg::ST_PU_OFF : prpe_pkg::ST_UP_RD;
      prpe_pkg::ST_PU_OFF: state_nxt = prpe_pkg::ST_PU_EDGE;
      prpe_pkg::ST_PU_EDGE: state_nxt = k_more ? prpe_pkg::ST_PU_SUM : prpe_pkg::ST_PU_RD;
      prpe_pkg::ST_PU_SUM: state_nxt = dst_ok ? prpe_pkg::ST_PU_ADD : prpe_pkg::ST_PU_EDGE;
      prpe_pkg::ST_PU_ADD: state_nxt = prpe_pkg::ST_PU_EDGE;
      prpe_pkg::ST_UP_RD: state_nxt = v_more ? prpe_pkg::ST_UP_MUL : prpe_pkg::ST_ROUND;
      prpe_pkg::ST_UP_MUL: state_nxt = prpe_pkg::ST_UP_WR;
      prpe_pkg::ST_UP_WR: state_nxt = prpe_pkg::ST_UP_RD;
      prpe_pkg::ST_READ: if (slot_free) state_nxt = prpe_pkg::ST_IDLE;
      prpe_pkg::ST_DONE: if (slot_free) state_nxt = prpe_pkg::ST_IDLE;
      default: state_nxt = prpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    vcnt_nxt = vcnt_r;
    nv_nxt = nv_r;
    rc_nxt = rc_r;
    k_nxt = k_r;
    hi_nxt = hi_r;
    sh_nxt = sh_r;
    d_nxt = d_r;
    prod_nxt = prod_r;
    oor_nxt = oor_r;
    vert_nxt = vert_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_vert_nxt = out_vert_r;
    out_rank_nxt = out_rank_r;
    out_done_nxt = out_done_r;
    off_we = 1'b0;
    off_re = 1'b0;
    off_waddr = VCW'(in_idx32);
    off_wdata = in_ch.value;
    edge_we = 1'b0;
    edge_re = 1'b0;
    edge_waddr = EAW'(in_idx32);
    edge_wdata = in_ch.value;
    cur_we = 1'b0;
    cur_re = 1'b0;
    cur_waddr = v_addr;
    cur_raddr = v_addr;
    cur_wdata = '0;
    sum_we = 1'b0;
    sum_re = 1'b0;
    sum_waddr = v_addr;
    sum_raddr = v_addr;
    sum_wdata = '0;
    shr_we = 1'b0;
    shr_re = 1'b0;
    shr_wdata = '0;
    div_start = 1'b0;
    case (state_r)
      prpe_pkg::ST_CLEAR: begin
        cur_we = 1'b1;
        sum_we = 1'b1;
        vcnt_nxt = clr_last ? '0 : VCW'(vcnt_r + 1'b1);
      end
      prpe_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.command)
            prpe_pkg::CMD_LOAD_OFFSET: off_we = in_idx32 <= 32'(MAX_VERTICES);
            prpe_pkg::CMD_LOAD_EDGE:   edge_we = in_idx32 < 32'(MAX_EDGES);
            prpe_pkg::CMD_RUN: begin
              nv_nxt = (32'(vc_r) > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(vc_r);
              vcnt_nxt = '0;
              rc_nxt = '0;
            end
            prpe_pkg::CMD_READ: begin
              cur_re = 1'b1;
              cur_raddr = VAW'(in_idx32);
              oor_nxt = in_idx32 >= 32'(MAX_VERTICES);
              vert_nxt = in_ch.index[prpe_pkg::OUT_VERT_W-1:0];
            end
            default: ;
          endcase
        end
      end
      prpe_pkg::ST_INIT: begin
        if (v_more) begin
          cur_we = 1'b1;
          cur_wdata = init_r;
          sum_we = 1'b1;
          vcnt_nxt = VCW'(vcnt_r + 1'b1);
        end else begin
          vcnt_nxt = '0;
        end
      end
      prpe_pkg::ST_ROUND: vcnt_nxt = '0;
      prpe_pkg::ST_SH_RD: begin
        if (v_more) begin
          off_re = 1'b1;
          cur_re = 1'b1;
        end else begin
          vcnt_nxt = '0;
        end
      end
      prpe_pkg::ST_SH_GO: begin
        if (deg_zero) begin
          shr_we = 1'b1;
          vcnt_nxt = VCW'(vcnt_r + 1'b1);
        end else begin
          div_start = 1'b1;
        end
      end
      prpe_pkg::ST_SH_DIV: begin
        if (div_done) begin
          shr_we = 1'b1;
          shr_wdata = div_quot;
          vcnt_nxt = VCW'(vcnt_r + 1'b1);
        end
      end
      prpe_pkg::ST_PU_RD: begin
        if (v_more) begin
          off_re = 1'b1;
          shr_re = 1'b1;
        end else begin
          vcnt_nxt = '0;
        end
      end
      prpe_pkg::ST_PU_OFF: begin
        k_nxt = lo_q;
        hi_nxt = hi_q;
        sh_nxt = shr_q;
      end
      prpe_pkg::ST_PU_EDGE: begin
        if (k_more) edge_re = 1'b1;
        else vcnt_nxt = VCW'(vcnt_r + 1'b1);
      end
      prpe_pkg::ST_PU_SUM: begin
        if (dst_ok) begin
          sum_re = 1'b1;
          sum_raddr = VAW'(edge_q);
          d_nxt = VAW'(edge_q);
        end else begin
          k_nxt = OW'(k_r + 1'b1);
        end
      end
      prpe_pkg::ST_PU_ADD: begin
        sum_we = 1'b1;
        sum_waddr = d_r;
        sum_wdata = push_sum[RW] ? '1 : push_sum[RW-1:0];
        k_nxt = OW'(k_r + 1'b1);
      end
      prpe_pkg::ST_UP_RD: begin
        if (v_more) begin
          sum_re = 1'b1;
        end else begin
          vcnt_nxt = '0;
          rc_nxt = 8'(rc_r + 1'b1);
        end
      end
      prpe_pkg::ST_UP_MUL: prod_nxt = PW'(damp_r) * PW'(sum_q);
      prpe_pkg::ST_UP_WR: begin
        cur_we = 1'b1;
        cur_wdata = upd_sum[RW] ? '1 : upd_sum[RW-1:0];
        sum_we = 1'b1;
        vcnt_nxt = VCW'(vcnt_r + 1'b1);
      end
      prpe_pkg::ST_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_vert_nxt = vert_r;
          out_rank_nxt = oor_r ? '0 : cur_q;
          out_done_nxt = 1'b0;
        end
      end
      prpe_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_vert_nxt = '0;
          out_rank_nxt = '0;
          out_done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (off_we) off_mem[off_waddr] <= off_wdata;
    if (off_re) begin
      lo_q <= off_mem[vcnt_r];
      hi_q <= off_mem[VCW'(vcnt_r + 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    if (edge_re) edge_q <= edge_mem[EAW'(k_r)];
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    if (cur_re) cur_q <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (shr_we) shr_mem[v_addr] <= shr_wdata;
    if (shr_re) shr_q <= shr_mem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prpe_pkg::ST_CLEAR;
      vcnt_r <= '0;
      nv_r <= '0;
      rc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vcnt_r <= vcnt_nxt;
      nv_r <= nv_nxt;
      rc_r <= rc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r <= k_nxt;
    hi_r <= hi_nxt;
    sh_r <= sh_nxt;
    d_r <= d_nxt;
    prod_r <= prod_nxt;
    oor_r <= oor_nxt;
    vert_r <= vert_nxt;
    out_vert_r <= out_vert_nxt;
    out_rank_r <= out_rank_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_ch.ready = state_r == prpe_pkg::ST_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.vertex = out_vert_r;
  assign out_ch.rank = out_rank_r;
  assign out_ch.done_res = out_done_r;

endmodule

### design/prpe_chk.sv
`timescale 1ns / 1ps

`include "pagerank_push_engine_core_macros.svh"

module prpe_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [prpe_pkg::OUT_VERT_W-1:0]     out_vertex,
  input logic [prpe_pkg::RANK_W-1:0]         out_rank,
  input logic                                out_done_res
);

  // A stalled result stays offered.
  `PRPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A finished run reports vertex zero and rank zero.
  `PRPE_ASSERT(a_done_zero, out_valid && out_done_res |-> out_vertex == '0 && out_rank == '0,
    "run result carries data")

  // The rank memory is being cleared right after reset, so no request is taken.
  `PRPE_ASSERT_ALWAYS(a_clear_busy, $rose(rst_n) |-> !in_ready, "request taken during clear")

endmodule

bind pagerank_push_engine_core prpe_chk u_prpe_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_vertex   (out_ch.vertex),
  .out_rank     (out_ch.rank),
  .out_done_res (out_ch.done_res)
);

### dv/prpe_rank_checker.sv
`timescale 1ns / 1ps

module prpe_rank_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [prpe_pkg::CMD_W-1:0]      in_command,
  input  logic [prpe_pkg::IDX_W-1:0]      in_index,
  input  logic [prpe_pkg::OFF_W-1:0]      in_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [prpe_pkg::OUT_VERT_W-1:0] out_vertex,
  input  logic [prpe_pkg::RANK_W-1:0]     out_rank,
  input  logic                            out_done_res,
  input  logic                            cfg_we,
  input  logic [prpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fails,
  output int                              pending
);

  localparam int NV_MAX = 1024;
  localparam int NE_MAX = 65536;
  localparam int RANK_W = prpe_pkg::RANK_W;
  localparam int OFF_W = prpe_pkg::OFF_W;
  localparam int OUT_VERT_W = prpe_pkg::OUT_VERT_W;
  localparam logic [63:0] RANK_TOP = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [OUT_VERT_W-1:0] vertex;
    logic [RANK_W-1:0]     rank;
    logic                  done_res;
  } rank_report_t;

  logic [OFF_W-1:0]  row_start [0:NV_MAX];
  logic [OFF_W-1:0]  edge_dest [0:NE_MAX-1];
  logic [RANK_W-1:0] rank_now [0:NV_MAX-1];
  logic [RANK_W-1:0] rank_acc [0:NV_MAX-1];
  logic [RANK_W-1:0] rank_share [0:NV_MAX-1];
  logic [10:0]       vertex_total;
  logic [15:0]       damp_q16;
  logic [RANK_W-1:0] teleport;
  logic [RANK_W-1:0] start_rank;
  logic [7:0]        rounds;
  rank_report_t      expected_reports[$];

  function automatic logic [RANK_W-1:0] clip_rank(logic [63:0] v);
    return (v > RANK_TOP) ? RANK_TOP[RANK_W-1:0] : v[RANK_W-1:0];
  endfunction

  function automatic void push_round(int nv);
    int lo, hi, deg, d;
    logic [63:0] prod;
    for (int v = 0; v < nv; v++) begin
      lo = row_start[v];
      hi = row_start[v+1];
      deg = (hi > lo) ? hi - lo : 0;
      rank_share[v] = (deg != 0) ? rank_now[v] / deg : '0;
    end
    for (int v = 0; v < nv; v++) begin
      lo = row_start[v];
      hi = row_start[v+1];
      for (int k = lo; k < hi && k < NE_MAX; k++) begin
        d = edge_dest[k];
        if (d < nv) rank_acc[d] = clip_rank(64'(rank_acc[d]) + 64'(rank_share[v]));
      end
    end
    for (int v = 0; v < nv; v++) begin
      prod = (64'(damp_q16) * 64'(rank_acc[v])) >> 16;
      rank_now[v] = clip_rank(64'(teleport) + prod);
      rank_acc[v] = '0;
    end
  endfunction

  function automatic void run_power_iteration();
    int nv;
    nv = (vertex_total > NV_MAX) ? NV_MAX : vertex_total;
    for (int v = 0; v < nv; v++) begin
      rank_now[v] = start_rank;
      rank_acc[v] = '0;
    end
    for (int r = 0; r < rounds; r++) push_round(nv);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    for (int v = 0; v < NV_MAX; v++) begin
      rank_now[v] = '0;
      rank_acc[v] = '0;
    end
  end

  always @(posedge clk) begin
    rank_report_t want;
    if (!rst_n) begin
      vertex_total <= 11'd1;
      damp_q16 <= 16'd55706;
      teleport <= '0;
      start_rank <= '0;
      rounds <= 8'd20;
    end else begin
      if (cfg_we) begin
        case (prpe_pkg::cfg_idx_t'(cfg_index))
          prpe_pkg::CFG_VERTEX_COUNT: vertex_total <= cfg_wdata[10:0];
          prpe_pkg::CFG_DAMPING:      damp_q16 <= cfg_wdata[15:0];
          prpe_pkg::CFG_TELEPORT:     teleport <= cfg_wdata;
          prpe_pkg::CFG_INIT_RANK:    start_rank <= cfg_wdata;
          prpe_pkg::CFG_ROUND_COUNT:  rounds <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (prpe_pkg::cmd_t'(in_command))
          prpe_pkg::CMD_LOAD_OFFSET: if (in_index <= NV_MAX) row_start[in_index] = in_value;
          prpe_pkg::CMD_LOAD_EDGE:   edge_dest[in_index] = in_value;
          prpe_pkg::CMD_RUN: begin
            run_power_iteration();
            expected_reports.push_back('{vertex: '0, rank: '0, done_res: 1'b1});
          end
          default: begin
            expected_reports.push_back('{vertex: in_index[OUT_VERT_W-1:0],
                rank: (in_index < NV_MAX) ? rank_now[in_index[9:0]] : '0, done_res: 1'b0});
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report("unexpected result", 64'(out_rank), 64'd0);
        end else begin
          want = expected_reports.pop_front();
          if (out_vertex !== want.vertex) report("vertex", out_vertex, want.vertex);
          if (out_rank !== want.rank) report("rank", out_rank, want.rank);
          if (out_done_res !== want.done_res) report("done_res", out_done_res, want.done_res);
        end
      end
    end
    pending = expected_reports.size();
  end

endmodule

### dv/tb_pagerank_push_engine_core.sv
`timescale 1ns / 1ps

module tb_pagerank_push_engine_core;

  localparam int CFG_IDX_W = prpe_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = prpe_pkg::CFG_DATA_W;
  localparam int IDX_W = prpe_pkg::IDX_W;
  localparam int OFF_W = prpe_pkg::OFF_W;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;
  localparam int IDLE_LIMIT = 400000;
  localparam int ITEM_GOAL = 1100;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fails;
  int pending;
  int items;
  int snd_idle;
  int rcv_stall;
  int stall_ask;
  int stall_seen;
  int stall_left;
  int quiet_cycles;
  bit edge_written [0:65535];

  prpe_req_if in_ch ();
  prpe_res_if out_ch ();

  pagerank_push_engine_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  prpe_rank_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
    .in_index(in_ch.index), .in_value(in_ch.value),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_vertex(out_ch.vertex),
    .out_rank(out_ch.rank), .out_done_res(out_ch.done_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_ask != stall_seen) begin
      stall_seen <= stall_ask;
      stall_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(prpe_pkg::cmd_t c, logic [IDX_W-1:0] i, logic [OFF_W-1:0] v);
    case ((items / 70) % 4)
      0: begin snd_idle = 0; rcv_stall = 0; end
      1: begin snd_idle = 62; rcv_stall = 0; end
      2: begin snd_idle = 0; rcv_stall = 62; end
      default: begin snd_idle = 19; rcv_stall = 19; end
    endcase
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.index <= i;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic set_config(int unsigned nv, int unsigned damp, int unsigned tele,
                            int unsigned init, int unsigned rnds);
    settle();
    cfg_write(prpe_pkg::CFG_VERTEX_COUNT, nv);
    cfg_write(prpe_pkg::CFG_DAMPING, damp);
    cfg_write(prpe_pkg::CFG_TELEPORT, tele);
    cfg_write(prpe_pkg::CFG_INIT_RANK, init);
    cfg_write(prpe_pkg::CFG_ROUND_COUNT, rnds);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_edge(int k, int nv);
    logic [OFF_W-1:0] dest;
    dest = ($urandom_range(99) < 5) ? OFF_W'($urandom_range(0, 131071))
                                    : OFF_W'($urandom_range(0, nv + 1));
    send(prpe_pkg::CMD_LOAD_EDGE, IDX_W'(k), dest);
    edge_written[k] = 1'b1;
  endtask

  task automatic build_and_run(int nv);
    int offs [0:16];
    int r;
    r = $urandom_range(99);
    offs[0] = (r < 80) ? $urandom_range(0, 300) :
              (r < 95) ? $urandom_range(0, 65535) : 65530;
    for (int v = 1; v <= nv; v++) begin
      if ($urandom_range(99) < 10 && offs[v-1] >= 2) offs[v] = offs[v-1] - $urandom_range(1, 2);
      else offs[v] = offs[v-1] + $urandom_range(0, 4);
    end
    for (int v = 0; v <= nv; v++) send(prpe_pkg::CMD_LOAD_OFFSET, IDX_W'(v), OFF_W'(offs[v]));
    for (int v = 0; v < nv; v++) begin
      for (int k = offs[v]; k < offs[v+1] && k < 65536; k++) begin
        if (!edge_written[k] || $urandom_range(1)) load_edge(k, nv);
      end
    end
    if ($urandom_range(99) < 30) begin
      send(prpe_pkg::CMD_LOAD_OFFSET, IDX_W'($urandom_range(1025, 65535)),
           OFF_W'($urandom()));
    end
    if ($urandom_range(99) < 30) load_edge($urandom_range(60000, 65535), nv);
    send(prpe_pkg::CMD_READ, IDX_W'($urandom_range(0, 65535)), OFF_W'($urandom()));
    send(prpe_pkg::CMD_RUN, IDX_W'($urandom()), OFF_W'($urandom()));
    for (int v = 0; v < nv + 2; v++) begin
      if ($urandom_range(99) < 70) send(prpe_pkg::CMD_READ, IDX_W'(v), OFF_W'($urandom()));
    end
  endtask

  initial begin
    int nv;
    int sel;
    bit squeezed;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = prpe_pkg::CMD_READ;
    in_ch.index = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    items = 0;
    snd_idle = 0;
    rcv_stall = 0;
    stall_ask = 0;
    stall_seen = 0;
    stall_left = 0;
    quiet_cycles = 0;
    squeezed = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: default settings, out-of-range indexes, zero rounds and saturation.
    send(prpe_pkg::CMD_LOAD_OFFSET, 16'd0, 17'd0);
    send(prpe_pkg::CMD_LOAD_OFFSET, 16'd1, 17'd1);
    send(prpe_pkg::CMD_LOAD_EDGE, 16'd0, 17'd0);
    edge_written[0] = 1'b1;
    send(prpe_pkg::CMD_RUN, 16'hFFFF, 17'h1FFFF);
    send(prpe_pkg::CMD_READ, 16'd0, 17'd0);
    send(prpe_pkg::CMD_READ, 16'hFFFF, 17'h1FFFF);
    send(prpe_pkg::CMD_READ, 16'd1024, 17'd0);
    send(prpe_pkg::CMD_LOAD_OFFSET, 16'hFFFF, 17'h1FFFF);
    send(prpe_pkg::CMD_LOAD_OFFSET, 16'd1025, 17'h1FFFF);
    send(prpe_pkg::CMD_LOAD_EDGE, 16'hFFFF, 17'h1FFFF);
    edge_written[65535] = 1'b1;
    settle();
    cfg_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    @(negedge clk);
    set_config(0, 0, 32'h1234_5678, 32'hFFFF_FFFF, 3);
    send(prpe_pkg::CMD_RUN, 16'd0, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd0, 17'd0);
    set_config(1, 65535, 0, 32'hFFFF_FFFF, 0);
    send(prpe_pkg::CMD_RUN, 16'd0, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd0, 17'd0);
    set_config(3, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send(prpe_pkg::CMD_LOAD_OFFSET, 16'd2, 17'd3);
    send(prpe_pkg::CMD_LOAD_OFFSET, 16'd3, 17'd1);
    send(prpe_pkg::CMD_LOAD_EDGE, 16'd1, 17'd0);
    send(prpe_pkg::CMD_LOAD_EDGE, 16'd2, 17'd2);
    edge_written[1] = 1'b1;
    edge_written[2] = 1'b1;
    send(prpe_pkg::CMD_RUN, 16'd0, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd0, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd2, 17'd0);

    // Whole rank memory: every row offset defined, almost every vertex without edges.
    set_config(1024, 40000, 32'h0010_0000, 32'h0020_0000, 2);
    for (int v = 3; v <= 1024; v++) send(prpe_pkg::CMD_LOAD_OFFSET, IDX_W'(v), 17'd3);
    send(prpe_pkg::CMD_LOAD_EDGE, 16'd2, 17'd1023);
    send(prpe_pkg::CMD_RUN, 16'd0, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd1023, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd1, 17'd0);
    set_config(2047, 55706, 32'h0000_1000, 32'h7FFF_FFFF, 1);
    send(prpe_pkg::CMD_RUN, 16'd0, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd1023, 17'd0);
    send(prpe_pkg::CMD_READ, 16'd0, 17'd0);

    while (items < ITEM_GOAL) begin
      nv = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 16);
      sel = $urandom_range(9);
      if (sel == 1 && nv > 4) nv = 4;
      case (sel)
        0: set_config(nv, $urandom_range(0, 65535), $urandom(), $urandom(), $urandom_range(1, 4));
        1: set_config(nv, 55706, 32'h0100_0000, 32'h2000_0000, 255);
        default: set_config(nv, ($urandom_range(1)) ? 55706 : $urandom_range(0, 65535),
                            $urandom_range(0, 32'h0400_0000), 32'h8000_0000 / nv,
                            $urandom_range(1, 8));
      endcase
      build_and_run(nv);
      if (!squeezed && items > 600) begin
        squeezed = 1'b1;
        settle();
        stall_ask <= stall_ask + 1;
        for (int j = 0; j < 40; j++) begin
          send(prpe_pkg::CMD_READ, IDX_W'($urandom_range(0, 1100)), OFF_W'($urandom()));
        end
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/prpe_pkg.sv
design/prpe_if.sv
design/prpe_div.sv
design/pagerank_push_engine_core.sv
design/prpe_chk.sv
dv/prpe_rank_checker.sv
dv/tb_pagerank_push_engine_core.sv
